// ----- design/sct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types, codes and helper functions for the source character
// tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int POS_W       = OFFSET_BITS;
  localparam int FIELD_W     = 16;
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int FIFO_LIMIT  = FIFO_DEPTH - 4;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_NAME = 3'd1;
  localparam logic [2:0] MODE_STR  = 3'd2;
  localparam logic [2:0] MODE_LT   = 3'd3;
  localparam logic [2:0] MODE_GT   = 3'd4;
  localparam logic [2:0] MODE_DONE = 3'd5;

  localparam logic [3:0] KIND_ERR     = 4'd0;
  localparam logic [3:0] KIND_NAME    = 4'd1;
  localparam logic [3:0] KIND_LBRACE  = 4'd2;
  localparam logic [3:0] KIND_RBRACE  = 4'd3;
  localparam logic [3:0] KIND_LPAREN  = 4'd4;
  localparam logic [3:0] KIND_RPAREN  = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_SHL     = 4'd7;
  localparam logic [3:0] KIND_SHR     = 4'd8;
  localparam logic [3:0] KIND_LT      = 4'd9;
  localparam logic [3:0] KIND_LE      = 4'd10;
  localparam logic [3:0] KIND_GT      = 4'd11;
  localparam logic [3:0] KIND_GE      = 4'd12;
  localparam logic [3:0] KIND_NEWLINE = 4'd13;
  localparam logic [3:0] KIND_END     = 4'd14;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_UNTERM  = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [1:0]         error_code;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] start_offset;
    logic [3:0]         tok_kind;
  } token_t;

  typedef struct packed {
    logic   last;
    token_t tok;
  } item_t;

  typedef struct packed {
    logic  push0;
    logic  push1;
    item_t item0;
    item_t item1;
  } push_t;

  typedef struct packed {
    logic       emit;
    logic [3:0] kind;
    logic       len_one;
    logic       err_set;
    logic       bump;
    logic       start_tok;
    logic [2:0] mode;
  } idle_t;

  function automatic logic is_name_byte(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic [FIELD_W-1:0] sat_len(logic [POS_W:0] v);
    logic [32:0] w;
    w = 33'(v);
    if (w > 33'h0FFFF) begin
      return '1;
    end
    return w[FIELD_W-1:0];
  endfunction

  function automatic idle_t idle_scan(logic [7:0] c, logic err_seen);
    idle_t r;
    r      = '0;
    r.mode = MODE_IDLE;
    r.kind = KIND_ERR;
    unique case (c)
      CH_NUL: begin
        r.emit = 1'b1; r.kind = KIND_END; r.mode = MODE_DONE;
      end
      CH_SPACE, CH_TAB: begin
      end
      CH_NL: begin
        r.emit = 1'b1; r.kind = KIND_NEWLINE; r.len_one = 1'b1; r.bump = 1'b1;
      end
      CH_LBRACE: begin
        r.emit = 1'b1; r.kind = KIND_LBRACE; r.len_one = 1'b1;
      end
      CH_RBRACE: begin
        r.emit = 1'b1; r.kind = KIND_RBRACE; r.len_one = 1'b1;
      end
      CH_LPAREN: begin
        r.emit = 1'b1; r.kind = KIND_LPAREN; r.len_one = 1'b1;
      end
      CH_RPAREN: begin
        r.emit = 1'b1; r.kind = KIND_RPAREN; r.len_one = 1'b1;
      end
      CH_LT: begin
        r.start_tok = 1'b1; r.mode = MODE_LT;
      end
      CH_GT: begin
        r.start_tok = 1'b1; r.mode = MODE_GT;
      end
      CH_QUOTE: begin
        r.start_tok = 1'b1; r.mode = MODE_STR;
      end
      default: begin
        if (is_name_byte(c)) begin
          r.start_tok = 1'b1; r.mode = MODE_NAME;
        end else if (!err_seen) begin
          r.emit = 1'b1; r.kind = KIND_ERR; r.len_one = 1'b1; r.err_set = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/sct_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_scan
// Input register, scanner state and the single-pass token step that yields
// up to two results per character.
// ----------------------------------------------------------------------------
module sct_scan (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_take_i,
  input  wire logic [7:0]     ch_i,
  output logic                busy_o,
  output sct_pkg::push_t      push_o
);
  import sct_pkg::*;

  logic             in_vld_q;
  logic [7:0]       ch_q;
  logic [2:0]       mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] ts_q, ts_d;
  logic [15:0]      line_q, line_d;
  logic             err_q, err_d;

  token_t           r0, r1;
  logic             v0, v1;
  idle_t            idl;
  logic             use_idle, idle_slot1;
  logic [POS_W:0]   diff, diff1;
  token_t           idle_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      ch_q <= ch_i;
    end
  end

  assign idl   = idle_scan(ch_q, err_q);
  assign diff  = {1'b0, pos_q} - {1'b0, ts_q};
  assign diff1 = diff + 1'b1;

  always_comb begin
    idle_tok.tok_kind     = idl.kind;
    idle_tok.start_offset = FIELD_W'(pos_q);
    idle_tok.token_length = idl.len_one ? FIELD_W'(1) : '0;
    idle_tok.line_number  = line_q;
    idle_tok.error_code   = idl.err_set ? ERR_UNKNOWN : ERR_NONE;
  end

  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    ts_d       = ts_q;
    line_d     = line_q;
    err_d      = err_q;
    v0         = 1'b0;
    v1         = 1'b0;
    use_idle   = 1'b0;
    idle_slot1 = 1'b0;
    r0.tok_kind     = KIND_NAME;
    r0.start_offset = FIELD_W'(ts_q);
    r0.token_length = sat_len(diff);
    r0.line_number  = line_q;
    r0.error_code   = ERR_NONE;
    r1 = idle_tok;
    if (in_vld_q && (mode_q != MODE_DONE)) begin
      if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end
      unique case (mode_q)
        MODE_NAME: begin
          if (!is_name_byte(ch_q)) begin
            v0 = 1'b1; use_idle = 1'b1; idle_slot1 = 1'b1;
          end
        end
        MODE_LT, MODE_GT: begin
          v0 = 1'b1;
          mode_d = MODE_IDLE;
          if (ch_q == ((mode_q == MODE_LT) ? CH_LT : CH_GT)) begin
            r0.tok_kind     = (mode_q == MODE_LT) ? KIND_SHL : KIND_SHR;
            r0.token_length = sat_len(diff1);
          end else if (ch_q == CH_EQ) begin
            r0.tok_kind     = (mode_q == MODE_LT) ? KIND_LE : KIND_GE;
            r0.token_length = sat_len(diff1);
          end else begin
            r0.tok_kind = (mode_q == MODE_LT) ? KIND_LT : KIND_GT;
            use_idle = 1'b1; idle_slot1 = 1'b1;
          end
        end
        MODE_STR: begin
          r0.tok_kind = KIND_STRING;
          if (ch_q == CH_QUOTE) begin
            v0 = 1'b1;
            r0.token_length = sat_len(diff1);
            mode_d = MODE_IDLE;
          end else if (ch_q == CH_NUL) begin
            v0 = 1'b1;
            v1 = 1'b1;
            r0.error_code = err_q ? ERR_NONE : ERR_UNTERM;
            err_d = 1'b1;
            r1.tok_kind     = KIND_END;
            r1.token_length = '0;
            r1.error_code   = ERR_NONE;
            mode_d = MODE_DONE;
          end else if (ch_q == CH_NL) begin
            if (line_q != 16'hFFFF) begin
              line_d = line_q + 16'd1;
            end
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase
      if (use_idle) begin
        mode_d = idl.mode;
        if (idl.start_tok) begin
          ts_d = pos_q;
        end
        if (idl.err_set) begin
          err_d = 1'b1;
        end
        if (idl.bump && (line_q != 16'hFFFF)) begin
          line_d = line_q + 16'd1;
        end
        if (idle_slot1) begin
          v1 = idl.emit;
        end else begin
          v0 = idl.emit;
          r0 = idle_tok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      ts_q   <= '0;
      line_q <= 16'd1;
      err_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      line_q <= line_d;
      err_q  <= err_d;
    end
  end

  assign busy_o           = in_vld_q;
  assign push_o.push0     = v0;
  assign push_o.push1     = v1;
  assign push_o.item0.tok = r0;
  assign push_o.item0.last = !v1;
  assign push_o.item1.tok = r1;
  assign push_o.item1.last = 1'b1;

endmodule
`default_nettype wire

// ----- design/sct_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_fifo
// Result queue that takes up to two results per cycle and delivers one
// result per transfer.
// ----------------------------------------------------------------------------
module sct_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sct_pkg::push_t        push_i,
  input  wire logic                  pop_i,
  output sct_pkg::item_t             head_o,
  output logic                       nonempty_o,
  output logic [sct_pkg::CNT_W-1:0]  count_o
);
  import sct_pkg::*;

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] wr_next;

  assign wr_next = wr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem[wr_q] <= push_i.item0;
    end
    if (push_i.push1) begin
      mem[wr_next] <= push_i.item1;
    end
  end

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.push0) + PTR_W'(push_i.push1);
    rd_d  = rd_q + PTR_W'(pop_i);
    cnt_d = cnt_q + CNT_W'(push_i.push0) + CNT_W'(push_i.push1) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o     = mem[rd_q];
  assign nonempty_o = (cnt_q != '0);
  assign count_o    = cnt_q;

endmodule
`default_nettype wire

// ----- design/source_char_tokenizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_char_tokenizer
// Streaming tokenizer for source text, one character per transfer.
// ----------------------------------------------------------------------------
// A result is offered once its character has passed the input register and been
// written into the result queue. Throughput: one character per cycle while not
// held off; results leave at one per cycle while the output is ready, so a
// character that yields two results is absorbed by the eight-entry result queue.
// Input is held off while queued results plus two for a character in the
// scanner exceed four.
// Reset clears the scanner to idle, offset 0, line 1, no error, queue empty.
module source_char_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [3:0] tok_kind, [19:4] start_offset, [35:20] token_length,
  // [51:36] line_number, [53:52] error_code, [55:54] zero
  output logic [55:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);
  import sct_pkg::*;

  logic             take, pop, busy;
  push_t            push;
  item_t            head;
  logic             nonempty;
  logic [CNT_W-1:0] count, reserve;

  assign reserve         = count + CNT_W'({busy, 1'b0});
  assign s_axis_tready_o = (reserve <= CNT_W'(FIFO_LIMIT));
  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  sct_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_take_i (take),
    .ch_i      (s_axis_tdata_i),
    .busy_o    (busy),
    .push_o    (push)
  );

  sct_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (pop),
    .head_o     (head),
    .nonempty_o (nonempty),
    .count_o    (count)
  );

  assign m_axis_tvalid_o = nonempty;
  assign m_axis_tdata_o  = {2'b00, head.tok};
  assign m_axis_tlast_o  = head.last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_second_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push1 |-> push.push0)
    else $error("second result pushed without first");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("second result of a character missing");

endmodule
`default_nettype wire
